[rtl/ctrm_pkg.sv]
// Package for the cache tag refill multi-hit checker.
// Holds the geometry constants, the transfer structs and the tag array row type.
// Depends on nothing; every other file in rtl imports it.
`default_nettype none

package ctrm_pkg;

   localparam int SETS      = 64;
   localparam int WAYS      = 8;
   localparam int MASK_BITS = 8;
   localparam int SET_BITS  = $clog2(SETS);
   localparam int WAY_BITS  = $clog2(WAYS);

   typedef struct packed {
      logic        refill_kind;
      logic [31:0] phys_tag;
      logic [5:0]  set_index;
      logic [7:0]  way_select_mask;
      logic [63:0] event_time;
   } req_type;

   typedef struct packed {
      logic        multi_hit;
      logic [7:0]  match_ways;
      logic        match_last_kind;
      logic [63:0] match_last_time;
      logic        way_error;
      logic        any_multi_hit_seen;
   } rsp_type;

   typedef struct packed {
      logic        valid;
      logic [31:0] tag;
      logic        kind;
      logic [63:0] stamp;
   } way_entry_type;

   typedef way_entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      rsp_type rsp;
      row_type new_row;
      logic    wr_en;
   } lookup_type;

endpackage

`default_nettype wire

[rtl/ctrm_tag_ram.sv]
// Tag array storage: one row of all ways per set, one write and one read port.
// The read data is registered. Depends on ctrm_pkg.
`default_nettype none

module ctrm_tag_ram (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [ctrm_pkg::SET_BITS-1:0] wr_addr,
   input  wire ctrm_pkg::row_type             wr_data,
   input  wire logic                          rd_en,
   input  wire logic [ctrm_pkg::SET_BITS-1:0] rd_addr,
   output ctrm_pkg::row_type                  rd_data
);
   import ctrm_pkg::*;

   row_type mem [SETS];
   row_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/ctrm_lookup.sv]
// Tag compare, lowest-match report, way mask check and updated row for one refill.
// Purely combinational. Depends on ctrm_pkg.
`default_nettype none

module ctrm_lookup (
   input  wire ctrm_pkg::req_type    req,
   input  wire ctrm_pkg::row_type    row,
   input  wire logic                 sticky,
   output ctrm_pkg::lookup_type      result
);
   import ctrm_pkg::*;

   logic [WAYS-1:0]     match;
   logic                hit;
   logic [7:0]          match_ways;
   logic                last_kind;
   logic [63:0]         last_time;
   logic                sel_ok;
   logic [WAY_BITS-1:0] sel_way;
   row_type             new_row;

   always_comb begin
      match      = '0;
      match_ways = '0;
      last_kind  = 1'b0;
      last_time  = '0;
      sel_ok     = 1'b0;
      sel_way    = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = row[w].valid && (row[w].tag == req.phys_tag);
      end
      hit = |match;
      for (int w = 0; w < MASK_BITS; w++) begin
         if (w < WAYS) begin
            match_ways[w] = match[w];
         end
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            last_kind = row[w].kind;
            last_time = row[w].stamp;
         end
      end
      for (int w = 0; w < WAYS && w < MASK_BITS; w++) begin
         if (req.way_select_mask == (MASK_BITS'(1) << w)) begin
            sel_ok  = 1'b1;
            sel_way = WAY_BITS'(w);
         end
      end
      new_row = row;
      if (sel_ok) begin
         new_row[sel_way].valid = 1'b1;
         new_row[sel_way].tag   = req.phys_tag;
         new_row[sel_way].kind  = req.refill_kind;
         new_row[sel_way].stamp = req.event_time;
      end
      result.rsp.multi_hit          = hit;
      result.rsp.match_ways         = match_ways;
      result.rsp.match_last_kind    = last_kind;
      result.rsp.match_last_time    = last_time;
      result.rsp.way_error          = !sel_ok;
      result.rsp.any_multi_hit_seen = sticky | hit;
      result.new_row                = new_row;
      result.wr_en                  = sel_ok;
   end

endmodule

`default_nettype wire

[rtl/cache_tag_refill_multihit_check.sv]
// Top level of the cache tag refill multi-hit checker: handshakes, pipeline and clear pass.
// Depends on ctrm_pkg, ctrm_tag_ram and ctrm_lookup.
//
//   Channel   Direction   Handshake               Payload
//   req_      in          req_valid / req_stall   ctrm_pkg::req_type
//   rsp_      out         rsp_valid / rsp_stall   ctrm_pkg::rsp_type
//
// One refill transfer is accepted per cycle while req_stall is low; it is registered into
// the lookup stage, and its result into the result register, from which it can transfer.
// The row read at acceptance and the row write from the item ahead are set by one
// RAM read port and one RAM write port; a same-set write is forwarded.
// After reset a clear pass zeroes all SETS (64) rows of the array; req_stall is high meanwhile.
// A stalled result holds its stage, and req_stall rises until a slot frees.
`default_nettype none

module cache_tag_refill_multihit_check (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ctrm_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ctrm_pkg::rsp_type      rsp_data
);
   import ctrm_pkg::*;

   logic                clr_active_ff, clr_active_in;
   logic [SET_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic                s1_valid_ff, s1_valid_in;
   req_type             s1_req_ff;
   logic                byp_ff, byp_in;
   row_type             byp_row_ff;
   logic                sticky_ff, sticky_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic                adv;
   logic                acc;
   logic [SET_BITS-1:0] req_set;
   logic [SET_BITS-1:0] s1_set;
   row_type             rd_row;
   row_type             s1_row;
   lookup_type          lk;
   logic                ram_wr_en;
   logic [SET_BITS-1:0] ram_wr_addr;
   row_type             ram_wr_data;

   assign req_set   = req_data.set_index[SET_BITS-1:0];
   assign s1_set    = s1_req_ff.set_index[SET_BITS-1:0];
   assign adv       = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = clr_active_ff || (s1_valid_ff && !adv);
   assign acc       = req_valid && !req_stall;
   assign s1_row    = byp_ff ? byp_row_ff : rd_row;

   ctrm_lookup u_lookup (
      .req    (s1_req_ff),
      .row    (s1_row),
      .sticky (sticky_ff),
      .result (lk)
   );

   always_comb begin
      if (clr_active_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_cnt_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = adv && lk.wr_en;
         ram_wr_addr = s1_set;
         ram_wr_data = lk.new_row;
      end
   end

   ctrm_tag_ram u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (acc),
      .rd_addr (req_set),
      .rd_data (rd_row)
   );

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_cnt_in    = clr_cnt_ff;
      if (clr_active_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == SET_BITS'(SETS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
      s1_valid_in = acc || (s1_valid_ff && !adv);
      byp_in      = acc ? (adv && lk.wr_en && (req_set == s1_set)) : byp_ff;
      sticky_in   = adv ? lk.rsp.any_multi_hit_seen : sticky_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_cnt_ff    <= '0;
         s1_valid_ff   <= 1'b0;
         byp_ff        <= 1'b0;
         sticky_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_cnt_ff    <= clr_cnt_in;
         s1_valid_ff   <= s1_valid_in;
         byp_ff        <= byp_in;
         sticky_ff     <= sticky_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_req_ff  <= req_data;
         byp_row_ff <= lk.new_row;
      end
      if (adv) begin
         rsp_data_ff <= lk.rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_no_item_during_clear: assert property (@(posedge clock) disable iff (reset)
      !(clr_active_ff && s1_valid_ff))
      else $error("An item is in flight during the clear pass.");

   a_accept_fills_stage: assert property (@(posedge clock) disable iff (reset)
      acc |=> s1_valid_ff)
      else $error("An accepted transfer did not reach the lookup stage.");

   a_sticky_holds: assert property (@(posedge clock) disable iff (reset)
      sticky_ff |=> sticky_ff)
      else $error("The multi-hit sticky flag fell without reset.");

   a_hit_sets_seen: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.multi_hit) |-> rsp_data_ff.any_multi_hit_seen)
      else $error("A multi-hit result does not report the sticky flag.");
`endif

endmodule

`default_nettype wire

[test/cache_tag_refill_multihit_check_tb.sv]
// Testbench for cache_tag_refill_multihit_check: directed and random refill transfers
// are checked against a tag array predictor kept in the testbench, with random idling.
// Depends on ctrm_pkg and the RTL of the block only.
`default_nettype none

module cache_tag_refill_multihit_check_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctrm_pkg::*;

   localparam bit KIND_MISS     = 1'b0;
   localparam bit KIND_PREFETCH = 1'b1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   bit          tag_valid [SETS][WAYS];
   bit [31:0]   tag_value [SETS][WAYS];
   bit          tag_kind  [SETS][WAYS];
   bit [63:0]   tag_stamp [SETS][WAYS];
   bit          hit_seen;
   rsp_type     pending_results [$];
   int          error_count = 0;
   int          stall_mode  = 0;
   int          mode_left   = 0;

   cache_tag_refill_multihit_check uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type predict_refill(input req_type item);
      rsp_type r;
      int      set_no;
      int      sel;
      int      w;
      bit      found;
      r      = '0;
      found  = 1'b0;
      sel    = -1;
      set_no = item.set_index % SETS;
      for (w = 0; w < WAYS; w++) begin
         if (tag_valid[set_no][w] && tag_value[set_no][w] == item.phys_tag) begin
            r.multi_hit = 1'b1;
            if (w < MASK_BITS) begin
               r.match_ways[w] = 1'b1;
            end
            if (!found) begin
               found             = 1'b1;
               r.match_last_kind = tag_kind[set_no][w];
               r.match_last_time = tag_stamp[set_no][w];
            end
         end
      end
      if (r.multi_hit) begin
         hit_seen = 1'b1;
      end
      for (w = 0; w < WAYS && w < MASK_BITS; w++) begin
         if (item.way_select_mask == (8'd1 << w)) begin
            sel = w;
         end
      end
      if (sel < 0) begin
         r.way_error = 1'b1;
      end else begin
         tag_valid[set_no][sel] = 1'b1;
         tag_value[set_no][sel] = item.phys_tag;
         tag_kind[set_no][sel]  = item.refill_kind;
         tag_stamp[set_no][sel] = item.event_time;
      end
      r.any_multi_hit_seen = hit_seen;
      return r;
   endfunction

   function automatic req_type make_refill(input bit kind, input bit [31:0] tag,
                                           input bit [5:0] set_no, input bit [7:0] mask,
                                           input bit [63:0] stamp);
      req_type item;
      item.refill_kind     = kind;
      item.phys_tag        = tag;
      item.set_index       = set_no;
      item.way_select_mask = mask;
      item.event_time      = stamp;
      return item;
   endfunction

   task automatic send_refill(input req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      pending_results.insert(pending_results.size(), predict_refill(item));
   endtask

   task automatic idle_cycles(input int count);
      req_valid <= 1'b0;
      repeat (count) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("%0t: mismatch in %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected transfer", rsp_data.match_last_time, '0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.multi_hit !== want.multi_hit)
               report_mismatch("multi_hit", 64'(rsp_data.multi_hit), 64'(want.multi_hit));
            if (rsp_data.match_ways !== want.match_ways)
               report_mismatch("match_ways", 64'(rsp_data.match_ways),
                               64'(want.match_ways));
            if (rsp_data.match_last_kind !== want.match_last_kind)
               report_mismatch("match_last_kind", 64'(rsp_data.match_last_kind),
                               64'(want.match_last_kind));
            if (rsp_data.match_last_time !== want.match_last_time)
               report_mismatch("match_last_time", rsp_data.match_last_time,
                               want.match_last_time);
            if (rsp_data.way_error !== want.way_error)
               report_mismatch("way_error", 64'(rsp_data.way_error), 64'(want.way_error));
            if (rsp_data.any_multi_hit_seen !== want.any_multi_hit_seen)
               report_mismatch("any_multi_hit_seen", 64'(rsp_data.any_multi_hit_seen),
                               64'(want.any_multi_hit_seen));
         end
      end
   end

   // The receiver switches between free running, light, heavy and periodic stalling.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         mode_left  <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 7) == 0);
         2: rsp_stall <= 1'($urandom_range(0, 1));
         default: rsp_stall <= ((mode_left % 5) < 2);
      endcase
   end

   task automatic test_edge_values();
      send_refill(make_refill(KIND_MISS, 32'h0, 6'd0, 8'h01, 64'h0));
      send_refill(make_refill(KIND_PREFETCH, 32'hFFFF_FFFF, 6'd63, 8'h80, '1));
      send_refill(make_refill(KIND_MISS, 32'hFFFF_FFFF, 6'd63, 8'h80, 64'h1));
      send_refill(make_refill(KIND_MISS, 32'h0, 6'd0, 8'h01, 64'h8000_0000_0000_0000));
   endtask

   task automatic test_lowest_match();
      send_refill(make_refill(KIND_MISS, 32'hA5A5_5A5A, 6'd21, 8'h40, 64'h100));
      send_refill(make_refill(KIND_PREFETCH, 32'hA5A5_5A5A, 6'd21, 8'h04, 64'h200));
      send_refill(make_refill(KIND_MISS, 32'hA5A5_5A5A, 6'd21, 8'h10, 64'h300));
      send_refill(make_refill(KIND_MISS, 32'h1234_5678, 6'd21, 8'h04, 64'h400));
      send_refill(make_refill(KIND_PREFETCH, 32'hA5A5_5A5A, 6'd21, 8'h00, 64'h500));
   endtask

   task automatic test_bad_way_masks();
      send_refill(make_refill(KIND_MISS, 32'h0BAD_F00D, 6'd42, 8'h00, 64'h10));
      send_refill(make_refill(KIND_PREFETCH, 32'h0BAD_F00D, 6'd42, 8'h03, 64'h11));
      send_refill(make_refill(KIND_MISS, 32'h0BAD_F00D, 6'd42, 8'hFF, 64'h12));
      send_refill(make_refill(KIND_PREFETCH, 32'h0BAD_F00D, 6'd42, 8'h81, 64'h13));
      send_refill(make_refill(KIND_MISS, 32'h0BAD_F00D, 6'd42, 8'h08, 64'h14));
      send_refill(make_refill(KIND_MISS, 32'h0BAD_F00D, 6'd42, 8'h50, 64'h15));
   endtask

   task automatic test_same_set_streaming();
      send_refill(make_refill(KIND_PREFETCH, 32'hC0DE_CAFE, 6'd9, 8'h80, 64'h21));
      send_refill(make_refill(KIND_MISS, 32'hC0DE_CAFE, 6'd9, 8'h20, 64'h22));
      send_refill(make_refill(KIND_PREFETCH, 32'hC0DE_CAFE, 6'd9, 8'h08, 64'h23));
      send_refill(make_refill(KIND_MISS, 32'hC0DE_CAFE, 6'd9, 8'h02, 64'h24));
      send_refill(make_refill(KIND_MISS, 32'hC0DE_CAFE, 6'd9, 8'h01, 64'h25));
   endtask

   task automatic test_drain_pause();
      send_refill(make_refill(KIND_PREFETCH, 32'h5555_AAAA, 6'd30, 8'h20, 64'h31));
      send_refill(make_refill(KIND_MISS, 32'h5555_AAAA, 6'd30, 8'h02, 64'h32));
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      send_refill(make_refill(KIND_MISS, 32'h5555_AAAA, 6'd30, 8'h00, 64'h33));
      send_refill(make_refill(KIND_PREFETCH, 32'h5555_AAAA, 6'd30, 8'h02, 64'h34));
   endtask

   // Most transfers go to a few hot sets with a few hot tags so that ways fill up and
   // repeat; the rest are spread over all sets, tags and way masks.
   task automatic test_random_refills(input int count);
      bit [5:0]  hot_set [4];
      bit [31:0] hot_tag [4];
      req_type   item;
      int        sent;
      int        burst;
      int        k;
      for (k = 0; k < 4; k++) begin
         hot_set[k] = 6'($urandom);
         hot_tag[k] = $urandom;
      end
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 7) == 0) begin
            hot_set[$urandom_range(0, 3)] = 6'($urandom);
            hot_tag[$urandom_range(0, 3)] = $urandom;
         end
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            item.refill_kind = 1'($urandom_range(0, 1));
            item.set_index   = ($urandom_range(0, 3) != 0) ? hot_set[$urandom_range(0, 3)]
                                                           : 6'($urandom);
            item.phys_tag    = ($urandom_range(0, 4) != 0) ? hot_tag[$urandom_range(0, 3)]
                                                           : $urandom;
            case ($urandom_range(0, 15))
               0: item.way_select_mask = 8'h00;
               1: item.way_select_mask = 8'($urandom);
               2: item.way_select_mask = (8'd1 << $urandom_range(0, 7))
                                       | (8'd1 << $urandom_range(0, 7));
               default: item.way_select_mask = 8'd1 << $urandom_range(0, 7);
            endcase
            item.event_time = {$urandom, $urandom};
            send_refill(item);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) begin
            idle_cycles($urandom_range(1, 6));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_edge_values();
      test_lowest_match();
      test_bad_way_masks();
      test_same_set_streaming();
      test_drain_pause();
      test_random_refills(1800);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS cache_tag_refill_multihit_check");
      end else begin
         $display("FAIL cache_tag_refill_multihit_check");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL cache_tag_refill_multihit_check");
      $finish;
   end

endmodule

`default_nettype wire

[filelist.f]
rtl/ctrm_pkg.sv
rtl/ctrm_tag_ram.sv
rtl/ctrm_lookup.sv
rtl/cache_tag_refill_multihit_check.sv
test/cache_tag_refill_multihit_check_tb.sv
